FILE: rtl/core/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock, off while in reset
`define AST_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every clock, including reset
`define AST_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/core/sac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types and constants of the set-associative cache tag store.
// ----------------------------------------------------------------------------
package sac_pkg;

  localparam int MAX_INDEX_BITS = 10;
  localparam int WAYS           = 8;
  localparam int ADDR_BITS      = 32;
  localparam int NUM_SETS       = 1 << MAX_INDEX_BITS;
  localparam int TAG_BITS       = ADDR_BITS - 2;
  localparam int AGE_BITS       = 3;
  localparam int WAY_BITS       = 3;
  localparam int AGE_MAX        = WAYS - 1;
  localparam int MEM_COST       = 100;
  localparam int CYCLE_MAX      = 65535;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_LRU_MODE       = 3'd0,
    REG_WRITE_ALLOCATE = 3'd1,
    REG_WRITE_BACK     = 3'd2,
    REG_INDEX_BITS     = 3'd3,
    REG_OFFSET_BITS    = 3'd4,
    REG_WAYS_IN_USE    = 3'd5
  } cfg_reg_t;

  typedef logic [MAX_INDEX_BITS-1:0] set_idx_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [AGE_BITS-1:0] age;
    logic                dirty;
    logic                valid;
  } line_t;

  typedef line_t [WAYS-1:0] row_t;

  localparam int ROW_BITS = $bits(row_t);

  // controller to datapath
  typedef struct packed {
    logic     rd_en;     // read the set of the incoming word
    logic     clr_en;    // clearing pass write
    set_idx_t clr_set;
    logic     eval_en;   // update the set and load the result register
  } sac_cmd_t;

endpackage

FILE: rtl/core/sac_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/sac_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_ctrl
// Sequencer: clearing pass after reset, accept, evaluate, result handoff.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output sac_pkg::sac_cmd_t cmd
);
  import sac_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL
  } state_t;

  state_t   state_r, state_nxt;
  set_idx_t clr_cnt_r, clr_cnt_nxt;
  logic     out_tvalid_r, out_tvalid_nxt;
  logic     out_free;
  logic     accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cmd            = '0;
    cmd.clr_set    = clr_cnt_r;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en  = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.rd_en = accept;
        if (accept) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        // hold the set until the result register can take the word
        if (out_free) begin
          cmd.eval_en    = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;

  `AST_CLK(a_no_read_in_clear, (state_r == S_CLEAR) |-> !cmd.rd_en && !cmd.eval_en, "access during clearing pass")
  `AST_CLK(a_accept_to_eval, accept |=> (state_r == S_EVAL), "accepted word not evaluated")
  `AST_CLK(a_eval_gives_word, cmd.eval_en |=> out_tvalid_r, "evaluated word not presented")
  `AST_CLK(a_clear_wraps, (state_r == S_CLEAR) && (&clr_cnt_r) |=> (state_r == S_IDLE), "clearing pass overrun")

endmodule

FILE: rtl/core/sac_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sac_dp
// Datapath: config registers, address split, set memory, way search,
// replacement, age update and cost calculation.
// ----------------------------------------------------------------------------
module sac_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [sac_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [sac_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic [sac_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  sac_pkg::sac_cmd_t                    cmd,
  output logic [sac_pkg::OUT_TDATA_W-1:0]      out_tdata
);
  import sac_pkg::*;

  logic       lru_mode_r, write_allocate_r, write_back_r;
  logic [3:0] index_bits_r, offset_bits_r, ways_in_use_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lru_mode_r       <= 1'b1;
      write_allocate_r <= 1'b1;
      write_back_r     <= 1'b1;
      index_bits_r     <= 4'd0;
      offset_bits_r    <= 4'd4;
      ways_in_use_r    <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_LRU_MODE:       lru_mode_r       <= cfg_wdata[0];
        REG_WRITE_ALLOCATE: write_allocate_r <= cfg_wdata[0];
        REG_WRITE_BACK:     write_back_r     <= cfg_wdata[0];
        REG_INDEX_BITS:     index_bits_r     <= cfg_wdata;
        REG_OFFSET_BITS:    offset_bits_r    <= cfg_wdata;
        REG_WAYS_IN_USE:    ways_in_use_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // clamped geometry
  logic [3:0] ib, ob, nw;
  assign ib = (index_bits_r > 4'(MAX_INDEX_BITS)) ? 4'(MAX_INDEX_BITS) : index_bits_r;
  assign ob = (offset_bits_r < 4'd2) ? 4'd2 : ((offset_bits_r > 4'd10) ? 4'd10 : offset_bits_r);
  assign nw = (ways_in_use_r == 4'd0) ? 4'd1
            : ((ways_in_use_r > 4'(WAYS)) ? 4'(WAYS) : ways_in_use_r);

  logic [ADDR_BITS-1:0] in_addr;
  logic [ADDR_BITS-1:0] in_shifted;
  set_idx_t             set_mask, in_set;
  assign in_addr    = in_tdata[ADDR_BITS-1:0];
  assign in_shifted = in_addr >> ob;
  assign set_mask   = set_idx_t'((1 << ib) - 1);
  assign in_set     = in_shifted[MAX_INDEX_BITS-1:0] & set_mask;

  // request latched at accept
  logic [ADDR_BITS-1:0] addr_r;
  logic                 store_r;
  set_idx_t             set_r;
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      addr_r  <= in_addr;
      store_r <= in_tdata[ADDR_BITS];
      set_r   <= in_set;
    end
  end

  row_t     row, new_row;
  logic     ram_we;
  set_idx_t ram_waddr;
  row_t     ram_wdata;

  assign ram_we    = cmd.clr_en || cmd.eval_en;
  assign ram_waddr = cmd.clr_en ? cmd.clr_set : set_r;
  assign ram_wdata = cmd.clr_en ? row_t'('0) : new_row;

  sac_ram #(.WIDTH(ROW_BITS), .DEPTH(NUM_SETS)) u_set_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (in_set),
    .rdata (row)
  );

  logic [ADDR_BITS-1:0] tag_full;
  logic [TAG_BITS-1:0]  tag;
  // shift amount reaches 20, so the sum needs five bits
  assign tag_full = addr_r >> (5'(ib) + 5'(ob));
  assign tag      = tag_full[TAG_BITS-1:0];

  logic [WAYS-1:0]     used;
  logic                hit_found, empty_found;
  logic [WAY_BITS-1:0] hit_way, empty_way, old_way, fill_way;
  logic                do_fill, wb;
  logic [16:0]         fill_cost, cycles_sum;
  logic [15:0]         cycles;

  always_comb begin
    hit_found   = 1'b0;
    hit_way     = '0;
    empty_found = 1'b0;
    empty_way   = '0;
    old_way     = '0;
    for (int w = 0; w < WAYS; w++) begin
      used[w] = (4'(w) < nw);
      if (!hit_found && used[w] && row[w].valid && row[w].tag == tag) begin
        hit_found = 1'b1;
        hit_way   = WAY_BITS'(w);
      end
      if (!empty_found && used[w] && !row[w].valid) begin
        empty_found = 1'b1;
        empty_way   = WAY_BITS'(w);
      end
      if (used[w] && row[w].age > row[old_way].age) begin
        old_way = WAY_BITS'(w);
      end
    end
  end

  always_comb begin
    do_fill    = !hit_found && (!store_r || write_allocate_r);
    fill_way   = empty_found ? empty_way : old_way;
    wb         = do_fill && !empty_found && write_back_r && row[old_way].dirty;
    fill_cost  = 17'(MEM_COST) << (ob - 4'd2);
    new_row    = row;
    cycles_sum = '0;
    if (hit_found) begin
      if (lru_mode_r) begin
        for (int w = 0; w < WAYS; w++) begin
          if (3'(w) != hit_way && used[w] && row[w].valid &&
              row[w].age < row[hit_way].age && row[w].age < 3'(AGE_MAX)) begin
            new_row[w].age = row[w].age + 1'b1;
          end
        end
        new_row[hit_way].age = '0;
      end
      if (!store_r) begin
        cycles_sum = 17'd1;
      end else if (write_back_r) begin
        new_row[hit_way].dirty = 1'b1;
        cycles_sum = 17'd1;
      end else begin
        cycles_sum = 17'(MEM_COST);
      end
    end else if (!do_fill) begin
      cycles_sum = 17'(MEM_COST);
    end else begin
      for (int w = 0; w < WAYS; w++) begin
        if (3'(w) != fill_way && used[w] && row[w].valid && row[w].age < 3'(AGE_MAX)) begin
          new_row[w].age = row[w].age + 1'b1;
        end
      end
      new_row[fill_way].age   = '0;
      new_row[fill_way].valid = 1'b1;
      new_row[fill_way].tag   = tag;
      new_row[fill_way].dirty = store_r && write_back_r;
      cycles_sum = fill_cost + (wb ? fill_cost : 17'd0);
      if (store_r) begin
        cycles_sum = cycles_sum + (write_back_r ? 17'd1 : 17'(MEM_COST + 1));
      end
    end
    cycles = (cycles_sum > 17'(CYCLE_MAX)) ? 16'(CYCLE_MAX) : cycles_sum[15:0];
  end

  logic [OUT_TDATA_W-1:0] out_tdata_r;
  always_ff @(posedge clk) begin
    if (cmd.eval_en) begin
      out_tdata_r <= {6'd0, wb, cycles, hit_found};
    end
  end

  assign out_tdata = out_tdata_r;

endmodule

FILE: rtl/core/set_assoc_cache_access.sv
`timescale 1ns / 1ps
// an accepted word is read from the set memory, then evaluated into its registered result word
// a new access is taken only once the last is evaluated (read-modify-write of the set memory)
// a full result register that is not taken holds the evaluate step
// reset: synchronous, active low; a clearing pass over all 1024 sets (one set a cycle)
// follows, during which no access is accepted; config writes are taken as ever
// ----------------------------------------------------------------------------
// set_assoc_cache_access
// Tag store of a set-associative cache with LRU or FIFO replacement.
// ----------------------------------------------------------------------------
module set_assoc_cache_access (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [sac_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [sac_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [sac_pkg::IN_TDATA_W-1:0]       in_tdata,   // address[31:0], operation[32]
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sac_pkg::OUT_TDATA_W-1:0]      out_tdata   // hit[0], cycles[16:1], wrote_back[17]
);
  import sac_pkg::*;

  sac_cmd_t cmd;

  sac_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  sac_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .out_tdata (out_tdata)
  );

endmodule
